@@ design/tqls_pkg.sv @@
// Shared types and constants for the least-loaded transmit queue selector.
`default_nettype none

package tqls_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned QueueW   = 6;
  localparam int unsigned CountW   = 16;
  localparam int unsigned BestW    = CountW + 1;
  localparam int unsigned LiveW    = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  // Largest number of transmit queues the system supports.
  localparam int unsigned MaxQueues = 64;
  localparam int unsigned MaxQW     = 11;

  // Running minimum starts above any real count.
  localparam logic [BestW-1:0] CountSentinel = {BestW{1'b1}};
  // A queue holding more than this many flows is shared.
  localparam logic [CountW-1:0] SharedLimit = CountW'(1);
  // Reset value of the live queue count.
  localparam logic [LiveW-1:0] LiveReset = LiveW'(64);

  // Selection algorithm codes; the unused code behaves as hash.
  typedef enum logic [1:0] {
    ALG_HASH     = 2'd0,
    ALG_EVEN     = 2'd1,
    ALG_OVERFLOW = 2'd2
  } alg_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALGORITHM    = 2'd0,
    CFG_SEGMENT_SHARED = 2'd1,
    CFG_LIVE_QUEUES  = 2'd2
  } cfg_idx_e;

  // Item kinds, on the input and on the result.
  typedef enum logic {
    ACT_SELECT  = 1'b0,
    ACT_SEGMENT = 1'b1
  } action_e;

  // One result word.
  typedef struct packed {
    logic              answer_kind;
    logic [QueueW-1:0] chosen_queue;
    logic              choice_valid;
    logic              needs_segment;
  } result_t;

endpackage

`default_nettype wire

@@ design/tx_queue_least_loaded_select.sv @@
// A result word is registered in the output queue when its item is accepted.
// Throughput: one item per cycle; a two-word output queue lets input continue while
// one result waits, so input stalls only when two results are waiting.
// Reset clears the configuration to its defaults, the running minimum, and the output queue.
// The selection state is one compare per item, so candidates stream back to back.
// Top level of the least-loaded transmit queue selector.
`default_nettype none

module tx_queue_least_loaded_select (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [tqls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [tqls_pkg::CfgDataW-1:0]   cfg_data_i,
  // Input item channel.
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic                            action_i,
  input  wire logic [tqls_pkg::QueueW-1:0]     queue_number_i,
  input  wire logic [tqls_pkg::CountW-1:0]     pending_count_i,
  input  wire logic                            is_overflow_queue_i,
  input  wire logic                            last_candidate_i,
  // Result channel.
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic                            answer_kind_o,
  output      logic [tqls_pkg::QueueW-1:0]     chosen_queue_o,
  output      logic                            choice_valid_o,
  output      logic                            needs_segment_o
);

  // Configuration registers.
  logic [1:0]                   algorithm_q;
  logic                         seg_shared_q;
  logic [tqls_pkg::LiveW-1:0]   live_count_q;

  // Running selection state.
  logic [tqls_pkg::QueueW-1:0]  best_queue_q, best_queue_d;
  logic [tqls_pkg::BestW-1:0]   best_count_q, best_count_d;
  logic                         empty_found_q, empty_found_d;

  // Output queue, two words deep.
  tqls_pkg::result_t            fifo_q [2];
  logic                         wr_ptr_q, rd_ptr_q;
  logic [1:0]                   fill_q, fill_d;

  logic                         in_fire;
  logic                         out_fire;
  logic                         push;
  tqls_pkg::result_t            res;

  logic [tqls_pkg::QueueW-1:0]  upd_queue;
  logic                         upd_empty;
  logic [tqls_pkg::QueueW-1:0]  pick;
  logic                         have;
  logic                         seg;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (fill_q != 2'd2);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (fill_q != 2'd0);
  assign out_fire    = out_valid_o & out_ready_i;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algorithm_q  <= tqls_pkg::ALG_HASH;
      seg_shared_q <= 1'b0;
      live_count_q <= tqls_pkg::LiveReset;
    end else if (cfg_valid_i) begin
      case (tqls_pkg::cfg_idx_e'(cfg_index_i))
        tqls_pkg::CFG_ALGORITHM:      algorithm_q  <= cfg_data_i[1:0];
        tqls_pkg::CFG_SEGMENT_SHARED: seg_shared_q <= cfg_data_i[0];
        tqls_pkg::CFG_LIVE_QUEUES:    live_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Candidate compare, pick and segmentation answer.
  always_comb begin
    // The running minimum including the current candidate.
    upd_queue = best_queue_q;
    if ({1'b0, pending_count_i} < best_count_q) begin
      upd_queue = queue_number_i;
    end
    upd_empty = empty_found_q | (pending_count_i == '0);

    case (tqls_pkg::alg_e'(algorithm_q))
      tqls_pkg::ALG_EVEN: begin
        pick = upd_queue;
        have = 1'b1;
      end
      tqls_pkg::ALG_OVERFLOW: begin
        pick = upd_empty ? upd_queue : queue_number_i;
        have = 1'b1;
      end
      default: begin
        pick = '0;
        have = 1'b0;
      end
    endcase
    // Picks beyond the live queues or the system limit are invalid.
    if ({1'b0, pick} >= live_count_q ||
        tqls_pkg::MaxQW'(pick) >= tqls_pkg::MaxQW'(tqls_pkg::MaxQueues)) begin
      have = 1'b0;
    end

    seg = (tqls_pkg::alg_e'(algorithm_q) == tqls_pkg::ALG_OVERFLOW) ? is_overflow_queue_i
                                                                    : 1'b0;
    if (seg_shared_q && pending_count_i > tqls_pkg::SharedLimit) begin
      seg = 1'b1;
    end

    // Result word and state update.
    res          = '0;
    push         = 1'b0;
    best_queue_d = best_queue_q;
    best_count_d = best_count_q;
    empty_found_d = empty_found_q;
    if (in_fire) begin
      if (action_i == tqls_pkg::ACT_SEGMENT) begin
        push              = 1'b1;
        res.answer_kind   = tqls_pkg::ACT_SEGMENT;
        res.needs_segment = seg;
      end else if (last_candidate_i) begin
        push              = 1'b1;
        res.answer_kind   = tqls_pkg::ACT_SELECT;
        res.chosen_queue  = have ? pick : '0;
        res.choice_valid  = have;
        best_queue_d      = '0;
        best_count_d      = tqls_pkg::CountSentinel;
        empty_found_d     = 1'b0;
      end else begin
        best_queue_d  = upd_queue;
        empty_found_d = upd_empty;
        if ({1'b0, pending_count_i} < best_count_q) begin
          best_count_d = {1'b0, pending_count_i};
        end
      end
    end

    fill_d = fill_q + {1'b0, push} - {1'b0, out_fire};
  end

  // Selection state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_queue_q  <= '0;
      best_count_q  <= tqls_pkg::CountSentinel;
      empty_found_q <= 1'b0;
    end else begin
      best_queue_q  <= best_queue_d;
      best_count_q  <= best_count_d;
      empty_found_q <= empty_found_d;
    end
  end

  // Output queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_fire) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Output queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign answer_kind_o   = fifo_q[rd_ptr_q].answer_kind;
  assign chosen_queue_o  = fifo_q[rd_ptr_q].chosen_queue;
  assign choice_valid_o  = fifo_q[rd_ptr_q].choice_valid;
  assign needs_segment_o = fifo_q[rd_ptr_q].needs_segment;

endmodule

`default_nettype wire
